[rtl/core/point_to_cylinder_distance_unit_macros.svh]
// Assertion macros for the point-to-cylinder distance RTL.
`ifndef POINT_TO_CYLINDER_DISTANCE_UNIT_MACROS_SVH
`define POINT_TO_CYLINDER_DISTANCE_UNIT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ptc_pkg.sv]
// Package: shared constants and register index codes for the distance unit.
package ptc_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int AXIS_WIDTH_DEF  = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROOT_X     = 3'd0,
      REG_ROOT_Y     = 3'd1,
      REG_ROOT_Z     = 3'd2,
      REG_AXIS_X     = 3'd3,
      REG_AXIS_Y     = 3'd4,
      REG_AXIS_Z     = 3'd5,
      REG_CYL_RADIUS = 3'd6
   } csr_index_type;

endpackage

[rtl/core/ptc_req_if.sv]
// Interface: query point channel.
interface ptc_req_if #(parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;

   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

[rtl/core/ptc_rsp_if.sv]
// Interface: distance result channel.
interface ptc_rsp_if #(parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] surface_distance;
   logic                          axis_invalid;

   modport source (output valid, surface_distance, axis_invalid, input ready);
   modport sink   (input valid, surface_distance, axis_invalid, output ready);
endinterface

[rtl/core/ptc_csr_if.sv]
// Interface: configuration register write channel.
interface ptc_csr_if #(parameter int DATA_WIDTH = ptc_pkg::COORD_WIDTH_DEF);
   logic                                  valid;
   logic                                  ready;
   logic [ptc_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [DATA_WIDTH-1:0]                 data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/ptc_cfg.sv]
// Configuration registers and axis length-squared computation.
module ptc_cfg #(
   parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF,
   parameter int AXIS_WIDTH  = ptc_pkg::AXIS_WIDTH_DEF,
   parameter int DATA_WIDTH  = ptc_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ptc_csr_if.sink                        csr_ch,
   output logic signed [COORD_WIDTH-1:0]  root_x,
   output logic signed [COORD_WIDTH-1:0]  root_y,
   output logic signed [COORD_WIDTH-1:0]  root_z,
   output logic signed [AXIS_WIDTH-1:0]   axis_x,
   output logic signed [AXIS_WIDTH-1:0]   axis_y,
   output logic signed [AXIS_WIDTH-1:0]   axis_z,
   output logic [COORD_WIDTH-2:0]         cyl_radius,
   output logic [2*AXIS_WIDTH-1:0]        axis_len_sq
);
   localparam int SQW = 2*AXIS_WIDTH;

   logic signed [COORD_WIDTH-1:0] root_x_ff, root_y_ff, root_z_ff;
   logic signed [AXIS_WIDTH-1:0]  axis_x_ff, axis_y_ff, axis_z_ff;
   logic [COORD_WIDTH-2:0]        radius_ff;
   logic signed [SQW-1:0]         sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [SQW-1:0]         sq_x_in, sq_y_in, sq_z_in;
   logic [SQW-1:0]                len_sq_ff, len_sq_in;
   logic                          wr_en;

   assign csr_ch.ready = 1'b1;
   assign wr_en = csr_ch.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_x_ff <= '0;
         root_y_ff <= '0;
         root_z_ff <= '0;
         axis_x_ff <= '0;
         axis_y_ff <= '0;
         axis_z_ff <= {1'b0, {(AXIS_WIDTH-1){1'b1}}};
         radius_ff <= '0;
      end else if (wr_en) begin
         unique case (ptc_pkg::csr_index_type'(csr_ch.index))
            ptc_pkg::REG_ROOT_X:     root_x_ff <= csr_ch.data[COORD_WIDTH-1:0];
            ptc_pkg::REG_ROOT_Y:     root_y_ff <= csr_ch.data[COORD_WIDTH-1:0];
            ptc_pkg::REG_ROOT_Z:     root_z_ff <= csr_ch.data[COORD_WIDTH-1:0];
            ptc_pkg::REG_AXIS_X:     axis_x_ff <= csr_ch.data[AXIS_WIDTH-1:0];
            ptc_pkg::REG_AXIS_Y:     axis_y_ff <= csr_ch.data[AXIS_WIDTH-1:0];
            ptc_pkg::REG_AXIS_Z:     axis_z_ff <= csr_ch.data[AXIS_WIDTH-1:0];
            ptc_pkg::REG_CYL_RADIUS: radius_ff <= csr_ch.data[COORD_WIDTH-2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      sq_x_in   = axis_x_ff * axis_x_ff;
      sq_y_in   = axis_y_ff * axis_y_ff;
      sq_z_in   = axis_z_ff * axis_z_ff;
      len_sq_in = SQW'($unsigned(sq_x_ff)) + SQW'($unsigned(sq_y_ff))
                + SQW'($unsigned(sq_z_ff));
   end

   always_ff @(posedge clock) begin
      sq_x_ff   <= sq_x_in;
      sq_y_ff   <= sq_y_in;
      sq_z_ff   <= sq_z_in;
      len_sq_ff <= len_sq_in;
   end

   assign root_x      = root_x_ff;
   assign root_y      = root_y_ff;
   assign root_z      = root_z_ff;
   assign axis_x      = axis_x_ff;
   assign axis_y      = axis_y_ff;
   assign axis_z      = axis_z_ff;
   assign cyl_radius  = radius_ff;
   assign axis_len_sq = len_sq_ff;
endmodule

[rtl/core/ptc_front.sv]
// Front pipeline: offset, cross product with the axis, and its squared norm.
module ptc_front #(
   parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF,
   parameter int AXIS_WIDTH  = ptc_pkg::AXIS_WIDTH_DEF,
   localparam int CW = COORD_WIDTH + 1 + AXIS_WIDTH,
   localparam int NW = 2*CW + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic signed [COORD_WIDTH-1:0] point_z,
   input  logic signed [COORD_WIDTH-1:0] root_x,
   input  logic signed [COORD_WIDTH-1:0] root_y,
   input  logic signed [COORD_WIDTH-1:0] root_z,
   input  logic signed [AXIS_WIDTH-1:0]  axis_x,
   input  logic signed [AXIS_WIDTH-1:0]  axis_y,
   input  logic signed [AXIS_WIDTH-1:0]  axis_z,
   output logic                          out_valid,
   output logic [NW-1:0]                 cross_norm_sq
);
   localparam int DW  = COORD_WIDTH + 1;
   localparam int PW  = CW;
   localparam int HL  = (CW + 1) / 2;
   localparam int HH  = CW - HL;
   localparam int SW  = 2*CW;
   localparam int NST = 6;

   logic [NST-1:0]        valid_ff;
   logic signed [DW-1:0]  d_ff [3];
   logic signed [DW-1:0]  d_in [3];
   logic signed [PW-1:0]  prod_ff [6];
   logic signed [PW-1:0]  prod_in [6];
   logic [CW-1:0]         c_ff [3];
   logic [CW-1:0]         c_in [3];
   logic [2*HL-1:0]       ll_ff [3];
   logic [CW-1:0]         lh_ff [3];
   logic [2*HH-1:0]       hh_ff [3];
   logic [2*HL-1:0]       ll_in [3];
   logic [CW-1:0]         lh_in [3];
   logic [2*HH-1:0]       hh_in [3];
   logic [SW-1:0]         sq_ff [3];
   logic [SW-1:0]         sq_in [3];
   logic [NW-1:0]         num_ff, num_in;
   logic signed [PW:0]    diff [3];

   always_comb begin
      d_in[0] = DW'(point_x) - DW'(root_x);
      d_in[1] = DW'(point_y) - DW'(root_y);
      d_in[2] = DW'(point_z) - DW'(root_z);

      prod_in[0] = d_ff[1] * PW'(axis_z);
      prod_in[1] = d_ff[2] * PW'(axis_y);
      prod_in[2] = d_ff[2] * PW'(axis_x);
      prod_in[3] = d_ff[0] * PW'(axis_z);
      prod_in[4] = d_ff[0] * PW'(axis_y);
      prod_in[5] = d_ff[1] * PW'(axis_x);

      for (int i = 0; i < 3; i++) begin
         diff[i] = (PW+1)'(prod_ff[2*i]) - (PW+1)'(prod_ff[2*i+1]);
         c_in[i] = diff[i][PW] ? CW'(-diff[i]) : CW'(diff[i]);
         ll_in[i] = c_ff[i][HL-1:0] * c_ff[i][HL-1:0];
         lh_in[i] = CW'(c_ff[i][HL-1:0]) * CW'(c_ff[i][CW-1:HL]);
         hh_in[i] = c_ff[i][CW-1:HL] * c_ff[i][CW-1:HL];
         sq_in[i] = (SW'(hh_ff[i]) << (2*HL)) + (SW'(lh_ff[i]) << (HL+1))
                  + SW'(ll_ff[i]);
      end

      num_in = NW'(sq_ff[0]) + NW'(sq_ff[1]) + NW'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         prod_ff <= prod_in;
         c_ff    <= c_in;
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hh_ff   <= hh_in;
         sq_ff   <= sq_in;
         num_ff  <= num_in;
      end
   end

   assign out_valid     = valid_ff[NST-1];
   assign cross_norm_sq = num_ff;
endmodule

[rtl/core/ptc_sqrt.sv]
// Pipelined restoring root: largest q with q*q*den <= num, one bit per stage.
module ptc_sqrt #(
   parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF,
   parameter int AXIS_WIDTH  = ptc_pkg::AXIS_WIDTH_DEF,
   localparam int NW   = 2*(COORD_WIDTH + 1 + AXIS_WIDTH) + 2,
   localparam int QB   = COORD_WIDTH + 2,
   localparam int DENW = 2*AXIS_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [NW-1:0]   num,
   input  logic [DENW-1:0] den,
   output logic            out_valid,
   output logic [QB-1:0]   root
);
   localparam int TW = NW + 1;
   localparam int YW = QB + DENW;

   logic [QB-1:0]   valid_ff;
   logic [NW-1:0]   r_ff   [QB];
   logic [YW-1:0]   y_ff   [QB];
   logic [QB-1:0]   q_ff   [QB];
   logic [NW-1:0]   r_src  [QB];
   logic [YW-1:0]   y_src  [QB];
   logic [QB-1:0]   q_src  [QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QB-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int B = QB - 1 - k;
      logic [TW-1:0] term;
      logic          take;
      logic [NW-1:0] r_in;
      logic [YW-1:0] y_in;
      logic [QB-1:0] q_in;

      if (k == 0) begin : g_first
         assign r_src[k] = num;
         assign y_src[k] = '0;
         assign q_src[k] = '0;
      end else begin : g_next
         assign r_src[k] = r_ff[k-1];
         assign y_src[k] = y_ff[k-1];
         assign q_src[k] = q_ff[k-1];
      end

      always_comb begin
         term = (TW'(y_src[k]) << (B+1)) + (TW'(den) << (2*B));
         take = TW'(r_src[k]) >= term;
         r_in = take ? r_src[k] - NW'(term) : r_src[k];
         y_in = take ? y_src[k] + (YW'(den) << B) : y_src[k];
         q_in = take ? q_src[k] | (QB'(1) << B) : q_src[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k] <= r_in;
            y_ff[k] <= y_in;
            q_ff[k] <= q_in;
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign root      = q_ff[QB-1];
endmodule

[rtl/core/point_to_cylinder_distance_unit.sv]
// Top level: signed distance from a query point to a cylinder surface.
// One point enters and one result leaves per clock while the output is not
// stalled. Six stages form the offset, cross product with the axis and its
// squared norm, COORD_WIDTH + 2 stages each resolve one bit of the root, and an
// output register subtracts the radius and saturates. A stalled result holds the
// whole pipeline. Write configuration only while no item is in flight; an
// all-zero axis flags every result invalid with distance 0.
`include "point_to_cylinder_distance_unit_macros.svh"

module point_to_cylinder_distance_unit #(
   parameter int COORD_WIDTH = ptc_pkg::COORD_WIDTH_DEF,
   parameter int AXIS_WIDTH  = ptc_pkg::AXIS_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ptc_req_if.sink   req_ch,
   ptc_rsp_if.source rsp_ch,
   ptc_csr_if.sink   csr_ch
);
   localparam int CSR_DW = (COORD_WIDTH > AXIS_WIDTH) ? COORD_WIDTH : AXIS_WIDTH;
   localparam int NW     = 2*(COORD_WIDTH + 1 + AXIS_WIDTH) + 2;
   localparam int QB     = COORD_WIDTH + 2;
   localparam int DENW   = 2*AXIS_WIDTH;
   localparam int SDW    = QB + 1;
   localparam logic signed [SDW-1:0] LIMIT_HI =
      {{(SDW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SDW-1:0] LIMIT_LO =
      {{(SDW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   logic signed [COORD_WIDTH-1:0] root_x, root_y, root_z;
   logic signed [AXIS_WIDTH-1:0]  axis_x, axis_y, axis_z;
   logic [COORD_WIDTH-2:0]        cyl_radius;
   logic [DENW-1:0]               axis_len_sq;
   logic                          en;
   logic                          front_valid;
   logic [NW-1:0]                 cross_norm_sq;
   logic                          root_valid;
   logic [QB-1:0]                 root;
   logic signed [SDW-1:0]         diff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_WIDTH-1:0] dist_ff, dist_in;
   logic                          inv_ff, inv_in;

   assign en = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   ptc_cfg #(
      .COORD_WIDTH (COORD_WIDTH),
      .AXIS_WIDTH  (AXIS_WIDTH),
      .DATA_WIDTH  (CSR_DW)
   ) u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_ch      (csr_ch),
      .root_x      (root_x),
      .root_y      (root_y),
      .root_z      (root_z),
      .axis_x      (axis_x),
      .axis_y      (axis_y),
      .axis_z      (axis_z),
      .cyl_radius  (cyl_radius),
      .axis_len_sq (axis_len_sq)
   );

   ptc_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .AXIS_WIDTH  (AXIS_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_ch.valid),
      .point_x       (req_ch.point_x),
      .point_y       (req_ch.point_y),
      .point_z       (req_ch.point_z),
      .root_x        (root_x),
      .root_y        (root_y),
      .root_z        (root_z),
      .axis_x        (axis_x),
      .axis_y        (axis_y),
      .axis_z        (axis_z),
      .out_valid     (front_valid),
      .cross_norm_sq (cross_norm_sq)
   );

   ptc_sqrt #(
      .COORD_WIDTH (COORD_WIDTH),
      .AXIS_WIDTH  (AXIS_WIDTH)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .num       (cross_norm_sq),
      .den       (axis_len_sq),
      .out_valid (root_valid),
      .root      (root)
   );

   always_comb begin
      diff         = $signed({1'b0, root}) - $signed(SDW'(cyl_radius));
      rsp_valid_in = root_valid;
      inv_in       = (axis_len_sq == '0);
      if (inv_in) begin
         dist_in = '0;
      end else if (diff > LIMIT_HI) begin
         dist_in = LIMIT_HI[COORD_WIDTH-1:0];
      end else if (diff < LIMIT_LO) begin
         dist_in = LIMIT_LO[COORD_WIDTH-1:0];
      end else begin
         dist_in = diff[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
         inv_ff  <= inv_in;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.surface_distance = dist_ff;
   assign rsp_ch.axis_invalid     = inv_ff;

   `PTC_ASSERT_NOW(a_invalid_zero, rsp_ch.valid && rsp_ch.axis_invalid, rsp_ch.surface_distance == '0, "invalid axis result must carry zero distance")
   `PTC_ASSERT_NOW(a_stall_holds_input, rsp_ch.valid && !rsp_ch.ready, !req_ch.ready, "input accepted while output stalled")
   `PTC_ASSERT_NOW(a_no_radius_nonneg, rsp_ch.valid && !rsp_ch.axis_invalid && cyl_radius == '0, !rsp_ch.surface_distance[COORD_WIDTH-1], "negative distance with zero radius")
   `PTC_ASSERT_NEXT(a_result_advances, rsp_ch.valid && rsp_ch.ready && !root_valid, !rsp_ch.valid, "result repeated after hand-off")
endmodule

[test/testbench.sv]
// Testbench for the point-to-cylinder surface distance unit: directed and random points.
`timescale 1ns / 100ps

module testbench;

   localparam int CW = ptc_pkg::COORD_WIDTH_DEF;
   localparam int AW = ptc_pkg::AXIS_WIDTH_DEF;
   localparam int PIPE_CYCLES = CW + 9;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [ptc_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;
   localparam logic signed [CW-1:0] DIST_MAX = {1'b0, {(CW-1){1'b1}}};

   typedef struct {
      logic signed [CW-1:0] dist_val;
      logic                 invalid;
   } distance_type;

   typedef struct {
      logic signed [CW-1:0] px, py, pz;
      bit                   typed;
      distance_type         want;
   } point_row_type;

   logic clock;
   logic reset;

   ptc_req_if #(.COORD_WIDTH(CW)) req_if ();
   ptc_rsp_if #(.COORD_WIDTH(CW)) rsp_if ();
   ptc_csr_if #(.DATA_WIDTH(CW))  csr_if ();

   point_to_cylinder_distance_unit #(.COORD_WIDTH(CW), .AXIS_WIDTH(AW)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // cylinder copy
   logic signed [CW-1:0] cyl_root_x, cyl_root_y, cyl_root_z;
   logic signed [AW-1:0] cyl_axis_x, cyl_axis_y, cyl_axis_z;
   logic [CW-2:0]        cyl_rad;

   distance_type pending_dist[$];
   int           mismatches;
   int           cycles;
   int           send_idle_pct;
   int           recv_stall_pct;
   int           recv_holdoff;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic distance_type surface_distance_of(logic signed [CW-1:0] px,
                                                        logic signed [CW-1:0] py,
                                                        logic signed [CW-1:0] pz);
      longint       ax, ay, az, dx, dy, dz, cx, cy, cz, den, sd;
      logic [127:0] num, lhs;
      longint       q, cand;
      distance_type r;
      ax = cyl_axis_x; ay = cyl_axis_y; az = cyl_axis_z;
      dx = longint'(px) - longint'(cyl_root_x);
      dy = longint'(py) - longint'(cyl_root_y);
      dz = longint'(pz) - longint'(cyl_root_z);
      den = ax * ax + ay * ay + az * az;
      if (den == 0) begin
         r.dist_val = '0;
         r.invalid = 1'b1;
         return r;
      end
      cx = dy * az - dz * ay; if (cx < 0) cx = -cx;
      cy = dz * ax - dx * az; if (cy < 0) cy = -cy;
      cz = dx * ay - dy * ax; if (cz < 0) cz = -cz;
      num = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
      q = 0;
      for (int b = CW + 1; b >= 0; b--) begin
         cand = q | (64'sd1 <<< b);
         lhs = 128'(cand) * 128'(cand) * 128'(den);
         if (lhs <= num) q = cand;
      end
      sd = q - longint'(cyl_rad);
      if (sd > longint'(DIST_MAX)) sd = DIST_MAX;
      if (sd < -(64'sd1 <<< (CW - 1))) sd = -(64'sd1 <<< (CW - 1));
      r.dist_val = sd[CW-1:0];
      r.invalid = 1'b0;
      return r;
   endfunction

   task automatic write_csr(logic [ptc_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [CW-1:0] value);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         ptc_pkg::REG_ROOT_X:     cyl_root_x = value;
         ptc_pkg::REG_ROOT_Y:     cyl_root_y = value;
         ptc_pkg::REG_ROOT_Z:     cyl_root_z = value;
         ptc_pkg::REG_AXIS_X:     cyl_axis_x = value[AW-1:0];
         ptc_pkg::REG_AXIS_Y:     cyl_axis_y = value[AW-1:0];
         ptc_pkg::REG_AXIS_Z:     cyl_axis_z = value[AW-1:0];
         ptc_pkg::REG_CYL_RADIUS: cyl_rad    = value[CW-2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic drain;
      wait (pending_dist.size() == 0);
      repeat (PIPE_CYCLES + 4) @(posedge clock);
   endtask

   // axis and radius values carry random junk above their used bits
   task automatic set_cylinder(logic signed [CW-1:0] rx, logic signed [CW-1:0] ry,
                               logic signed [CW-1:0] rz, logic signed [AW-1:0] ax,
                               logic signed [AW-1:0] ay, logic signed [AW-1:0] az,
                               logic [CW-2:0] rad);
      logic [CW-1:0] junk;
      drain();
      junk = CW'($urandom);
      write_csr(ptc_pkg::REG_ROOT_X, rx);
      write_csr(ptc_pkg::REG_ROOT_Y, ry);
      write_csr(ptc_pkg::REG_ROOT_Z, rz);
      write_csr(ptc_pkg::REG_AXIS_X, {junk[CW-1:AW], ax});
      write_csr(ptc_pkg::REG_AXIS_Y, {~junk[CW-1:AW], ay});
      write_csr(ptc_pkg::REG_AXIS_Z, {junk[CW-1:AW], az});
      write_csr(ptc_pkg::REG_CYL_RADIUS, {junk[0], rad});
   endtask

   task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                             logic signed [CW-1:0] pz, bit typed, distance_type want);
      distance_type e;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.point_x = px;
      req_if.point_y = py;
      req_if.point_z = pz;
      do @(posedge clock); while (!req_if.ready);
      e = typed ? want : surface_distance_of(px, py, pz);
      pending_dist = {pending_dist, e};
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   function automatic logic signed [CW-1:0] rand_coord(int span);
      logic signed [CW-1:0] v;
      v = CW'($urandom);
      if (span > 0) v = CW'($signed($urandom_range(2 * span)) - span);
      return v;
   endfunction

   task automatic random_points(int count);
      distance_type none;
      int span;
      none = '{dist_val: '0, invalid: 1'b0};
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: span = 0;
            1: span = 4000;
            2: span = 200000;
            default: span = 2000000;
         endcase
         send_point(rand_coord(span), rand_coord(span), rand_coord(span), 1'b0, none);
      end
   endtask

   always @(negedge clock) begin
      if (recv_holdoff > 0) begin
         rsp_if.ready <= 1'b0;
         recv_holdoff <= recv_holdoff - 1;
      end else begin
         rsp_if.ready <= !($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      distance_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_dist.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: dist %0d invalid %0b",
                                           rsp_if.surface_distance, rsp_if.axis_invalid);
         end else begin
            e = pending_dist.pop_front();
            if (e.dist_val !== rsp_if.surface_distance ||
                e.invalid !== rsp_if.axis_invalid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected dist %0d invalid %0b, got dist %0d invalid %0b",
                           e.dist_val, e.invalid, rsp_if.surface_distance,
                           rsp_if.axis_invalid);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      point_row_type rows_up[$];
      point_row_type rows_flat[$];
      distance_type  none;
      none = '{dist_val: '0, invalid: 1'b0};
      mismatches = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      recv_holdoff = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.point_x = '0;
      req_if.point_y = '0;
      req_if.point_z = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = ptc_pkg::REG_ROOT_X;
      csr_if.data = '0;
      cyl_root_x = '0; cyl_root_y = '0; cyl_root_z = '0;
      cyl_axis_x = '0; cyl_axis_y = '0; cyl_axis_z = {1'b0, {(AW-1){1'b1}}};
      cyl_rad = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset cylinder: vertical axis through origin, zero radius
      rows_up = '{
         '{0, 0, 0, 1, '{0, 0}},
         '{3072, 4096, 5, 1, '{5120, 0}},
         '{-3072, -4096, -8388608, 1, '{5120, 0}},
         '{8388607, 0, 8388607, 1, '{8388607, 0}},
         '{-8388608, 0, 0, 1, '{8388607, 0}},
         '{-8388608, -8388608, 1, 1, '{8388607, 0}},
         '{0, 0, -8388608, 1, '{0, 0}},
         '{1, -1, 77, 1, '{1, 0}},
         '{123456, -654321, 42, 0, '{0, 0}}
      };
      foreach (rows_up[i])
         send_point(rows_up[i].px, rows_up[i].py, rows_up[i].pz, rows_up[i].typed,
                    rows_up[i].want);

      // zero-length axis flags every item
      set_cylinder(100, -100, 5, 0, 0, 0, 999);
      rows_flat = '{
         '{8388607, 8388607, 8388607, 1, '{0, 1}},
         '{-8388608, -8388608, -8388608, 1, '{0, 1}},
         '{0, 0, 0, 1, '{0, 1}},
         '{12345, -1, 7, 1, '{0, 1}}
      };
      foreach (rows_flat[i])
         send_point(rows_flat[i].px, rows_flat[i].py, rows_flat[i].pz, rows_flat[i].typed,
                    rows_flat[i].want);
      drain();
      write_csr(REG_UNUSED, 24'hABCDEF);

      // extremes of root, axis and radius, predictor checked
      set_cylinder(8388607, -8388608, 8388607, -32768, -32768, -32768, 23'h7FFFFF);
      send_point(-8388608, 8388607, -8388608, 1'b0, none);
      send_point(8388607, -8388608, 8388607, 1'b0, none);
      send_point(0, 0, 0, 1'b0, none);
      set_cylinder(-8388608, 8388607, 0, 32767, 1, -1, 0);
      send_point(8388607, -8388608, 8388607, 1'b0, none);
      send_point(-8388608, 8388607, 0, 1'b0, none);
      set_cylinder(0, 0, 0, 1, 0, 0, 1000);
      send_point(0, 1000, 0, 1'b0, none);
      send_point(5, 0, 500, 1'b0, none);
      send_point(8388607, 8388607, -8388608, 1'b0, none);

      // random phases over varied cylinders
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         case (ph)
            0: set_cylinder(0, 0, 0, 0, 0, 32767, 4000);
            1: set_cylinder(1000, -2000, 300, 23170, 23170, 0, 150000);
            3: set_cylinder(0, 0, 0, 0, 0, 0, 5);
            4: set_cylinder(-8388608, -8388608, -8388608, 32767, 32767, 32767, 0);
            default: set_cylinder(rand_coord(0), rand_coord(0), rand_coord(0),
                                  AW'($urandom), AW'($urandom), AW'($urandom),
                                  (CW-1)'($urandom));
         endcase
         if (ph == 2) recv_holdoff = 300;
         random_points(52);
         if (ph == 5) drain();
      end

      wait (pending_dist.size() == 0);
      repeat (PIPE_CYCLES + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[point_to_cylinder_distance_unit.f]
+incdir+rtl/core
rtl/core/ptc_pkg.sv
rtl/core/ptc_req_if.sv
rtl/core/ptc_rsp_if.sv
rtl/core/ptc_csr_if.sv
rtl/core/ptc_cfg.sv
rtl/core/ptc_front.sv
rtl/core/ptc_sqrt.sv
rtl/core/point_to_cylinder_distance_unit.sv
test/testbench.sv
